// File: hdl/nhps_pkg.sv
// Shared widths, register codes and index helpers for the neo-Hookean stress unit.
package nhps_pkg;

    localparam int LIMB    = 32;
    localparam int FW      = 32;
    localparam int CW      = 38;
    localparam int ADJW    = 77;
    localparam int DETW    = 117;
    localparam int DW      = 89;
    localparam int AJW     = 49;
    localparam int DMW     = 90;
    localparam int KRW     = 123;
    localparam int KW      = 82;
    localparam int QW      = 110;
    localparam int NUMW    = 112;
    localparam int REMW    = 90;
    localparam int KQW     = KW + QW;
    localparam int SW      = 48;
    localparam int VW      = KQW - 48 + 1;
    localparam int PW      = FW + SW;
    localparam int PSW     = PW + 2;
    localparam int PQW     = PSW - 28;
    localparam int CSW     = 2 * FW + 2;
    localparam int MUW     = 31;
    localparam int NU      = 6;
    localparam int NE      = 9;
    localparam int FRAC    = 28;
    localparam int QSH     = 60;
    localparam int KSH     = 41;
    localparam int SSH     = 48;
    localparam int DOFF    = 56;
    localparam int MUSH    = 57;
    localparam int MUL_LAT = 5;
    localparam int DIV_BPS = 2;
    localparam int DIV_ST  = NUMW / DIV_BPS;

    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef enum logic [1:0] {
        REG_SHEAR = 2'd0,
        REG_LAME  = 2'd1,
        REG_MODE  = 2'd2
    } t_reg_idx;

    typedef logic signed [FW-1:0]   t_f;
    typedef logic signed [CW-1:0]   t_c;
    typedef logic signed [ADJW-1:0] t_adj;
    typedef logic signed [SW-1:0]   t_s;

    localparam int UI [NU] = '{0, 0, 0, 1, 1, 2};
    localparam int UJ [NU] = '{0, 1, 2, 1, 2, 2};

    // slot of a symmetric 3x3 entry in upper-triangle order
    function automatic int uidx(input int i, input int j);
        int lo;
        int hi;
        lo = (i < j) ? i : j;
        hi = (i < j) ? j : i;
        return (lo == 0) ? hi : ((lo == 1) ? hi + 2 : 5);
    endfunction

endpackage

// File: hdl/nhps_mul.sv
// Pipelined signed multiplier built from 32x32 limb products, five register stages.
module nhps_mul #(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [A_W-1:0]    i_a,
    input  logic signed [B_W-1:0]    i_b,
    output logic signed [A_W+B_W-1:0] o_p
);

    localparam int L  = nhps_pkg::LIMB;
    localparam int CA = (A_W + L - 1) / L;
    localparam int CB = (B_W + L - 1) / L;
    localparam int PW = L * (CA + CB);
    localparam int OW = A_W + B_W;

    logic [A_W-1:0]    w_aabs;
    logic [B_W-1:0]    w_babs;
    logic [L*CA-1:0]   r_ma;
    logic [L*CB-1:0]   r_mb;
    logic [3:0]        r_neg;
    logic [2*L-1:0]    r_pp [CA][CB];
    logic [PW-1:0]     r_row [CA];
    logic [PW-1:0]     n_row [CA];
    logic [PW-1:0]     r_sum;
    logic [PW-1:0]     n_sum;
    logic signed [OW-1:0] w_mag;
    logic signed [OW-1:0] r_p;

    assign w_aabs = i_a[A_W-1] ? (~i_a + 1'b1) : i_a;
    assign w_babs = i_b[B_W-1] ? (~i_b + 1'b1) : i_b;
    assign w_mag  = OW'(r_sum);

    always_comb begin
        for (int i = 0; i < CA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < CB; j++) begin
                n_row[i] = n_row[i] + (PW'(r_pp[i][j]) << (L * j));
            end
        end
        n_sum = '0;
        for (int i = 0; i < CA; i++) begin
            n_sum = n_sum + (r_row[i] << (L * i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma  <= (L*CA)'(w_aabs);
            r_mb  <= (L*CB)'(w_babs);
            r_neg <= {r_neg[2:0], i_a[A_W-1] ^ i_b[B_W-1]};
            for (int i = 0; i < CA; i++) begin
                for (int j = 0; j < CB; j++) begin
                    r_pp[i][j] <= (2*L)'(r_ma[L*i +: L]) * (2*L)'(r_mb[L*j +: L]);
                end
            end
            r_row <= n_row;
            r_sum <= n_sum;
            r_p   <= r_neg[3] ? -w_mag : w_mag;
        end
    end

    assign o_p = r_p;

endmodule

// File: hdl/neo_hookean_piola_stress_unit.sv
// Neo-Hookean second or first Piola-Kirchhoff stress from a 3x3 deformation gradient.
// Throughput: one item per cycle; every stage advances together, and a held output
// freezes the whole pipeline. The 56-stage restoring divider for C^-1 sets the depth.
// Reset (synchronous, active low) empties the pipeline and loads shear modulus and
// Lame parameter with 1.0 and selects second Piola-Kirchhoff output.
module neo_hookean_piola_stress_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [31:0]   i_grad_00,
    input  logic signed [31:0]   i_grad_01,
    input  logic signed [31:0]   i_grad_02,
    input  logic signed [31:0]   i_grad_10,
    input  logic signed [31:0]   i_grad_11,
    input  logic signed [31:0]   i_grad_12,
    input  logic signed [31:0]   i_grad_20,
    input  logic signed [31:0]   i_grad_21,
    input  logic signed [31:0]   i_grad_22,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [47:0]   o_stress_00,
    output logic signed [47:0]   o_stress_01,
    output logic signed [47:0]   o_stress_02,
    output logic signed [47:0]   o_stress_10,
    output logic signed [47:0]   o_stress_11,
    output logic signed [47:0]   o_stress_12,
    output logic signed [47:0]   o_stress_20,
    output logic signed [47:0]   o_stress_21,
    output logic signed [47:0]   o_stress_22,
    output logic                 o_singular,
    output logic                 o_saturated,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int FW   = nhps_pkg::FW;
    localparam int CW   = nhps_pkg::CW;
    localparam int ADJW = nhps_pkg::ADJW;
    localparam int DETW = nhps_pkg::DETW;
    localparam int DW   = nhps_pkg::DW;
    localparam int AJW  = nhps_pkg::AJW;
    localparam int DMW  = nhps_pkg::DMW;
    localparam int KRW  = nhps_pkg::KRW;
    localparam int KW   = nhps_pkg::KW;
    localparam int QW   = nhps_pkg::QW;
    localparam int NUMW = nhps_pkg::NUMW;
    localparam int REMW = nhps_pkg::REMW;
    localparam int KQW  = nhps_pkg::KQW;
    localparam int SW   = nhps_pkg::SW;
    localparam int VW   = nhps_pkg::VW;
    localparam int PW   = nhps_pkg::PW;
    localparam int PSW  = nhps_pkg::PSW;
    localparam int PQW  = nhps_pkg::PQW;
    localparam int CSW  = nhps_pkg::CSW;
    localparam int MUW  = nhps_pkg::MUW;
    localparam int NU   = nhps_pkg::NU;
    localparam int NE   = nhps_pkg::NE;
    localparam int ML   = nhps_pkg::MUL_LAT;
    localparam int DST  = nhps_pkg::DIV_ST;
    localparam int DBPS = nhps_pkg::DIV_BPS;

    localparam int T_C    = 3;
    localparam int T_ADJ  = T_C + ML + 1;
    localparam int T_D    = T_ADJ + ML + 1;
    localparam int T_DV0  = T_D + 1;
    localparam int T_K    = T_DV0 + ML + 1;
    localparam int T_Q    = T_DV0 + DST + 1;
    localparam int T_S    = T_Q + ML + 1;
    localparam int T_PS   = T_S + ML + 1;
    localparam int LAT    = T_PS + 1;
    localparam int CD_LEN = T_ADJ - T_C;
    localparam int AD_LEN = T_D - T_ADJ;
    localparam int KD_LEN = T_Q - T_K;
    localparam int FD_LEN = T_S - 1;
    localparam int SD_LEN = T_PS - T_S;
    localparam int GD_LEN = T_PS - T_DV0 + 1;

    localparam logic signed [DMW-1:0] D_ONE = DMW'(1) <<< nhps_pkg::DOFF;

    // control and configuration
    logic                 w_en;
    logic [LAT-1:0]       r_vld;
    logic [MUW-1:0]       r_mu;
    logic [MUW-1:0]       r_lam;
    logic                 r_mode;
    logic                 w_wr;

    // datapath
    nhps_pkg::t_f         w_grad [NE];
    nhps_pkg::t_f         r_f [NE];
    nhps_pkg::t_f         r_f_d [FD_LEN][NE];
    logic signed [2*FW-1:0] r_fp [NU][3];
    nhps_pkg::t_c         r_c [NU];
    nhps_pkg::t_c         n_c [NU];
    nhps_pkg::t_c         r_c_d [CD_LEN][NU];
    logic signed [2*CW-1:0] w_adjp [NU][2];
    nhps_pkg::t_adj       r_adj [NU];
    nhps_pkg::t_adj       r_adj_d [AD_LEN][NU];
    logic signed [CW+ADJW-1:0] w_detp [3];
    logic signed [DW-1:0] r_d;
    logic signed [DW-1:0] n_d;
    logic signed [DMW-1:0] r_dm;
    logic signed [DMW+FW-1:0] w_kp;
    logic signed [KW-1:0] r_k;
    logic signed [KW-1:0] n_k;
    logic signed [KW-1:0] r_k_d [KD_LEN];
    logic [REMW-1:0]      r_dv_rem [DST+1][NU];
    logic [NUMW-1:0]      r_dv_nq  [DST+1][NU];
    logic [DW-1:0]        r_dv_den [DST+1][NU];
    logic                 r_dv_neg [DST+1][NU];
    logic [REMW-1:0]      n_dv_rem [DST+1][NU];
    logic [NUMW-1:0]      n_dv_nq  [DST+1][NU];
    logic [DW-1:0]        n_dv_den [DST+1][NU];
    logic                 n_dv_neg [DST+1][NU];
    logic signed [QW-1:0] r_q [NU];
    logic signed [QW-1:0] n_q [NU];
    logic signed [KQW-1:0] w_kq [NU];
    nhps_pkg::t_s         r_s [NU];
    nhps_pkg::t_s         n_s [NU];
    logic [NU-1:0]        r_ssat;
    logic [NU-1:0]        n_ssat;
    nhps_pkg::t_s         r_s_d [SD_LEN][NU];
    logic [NU-1:0]        r_ssat_d [SD_LEN];
    logic [GD_LEN-1:0]    r_sing_d;
    logic signed [PW-1:0] w_pp [NE][3];
    logic signed [PQW-1:0] r_psum [NE];
    logic signed [PQW-1:0] n_psum [NE];
    nhps_pkg::t_s         r_stress [NE];
    nhps_pkg::t_s         n_stress [NE];
    logic                 r_sing;
    logic                 r_sat;
    logic                 n_sat;

    assign w_grad[0] = i_grad_00;
    assign w_grad[1] = i_grad_01;
    assign w_grad[2] = i_grad_02;
    assign w_grad[3] = i_grad_10;
    assign w_grad[4] = i_grad_11;
    assign w_grad[5] = i_grad_12;
    assign w_grad[6] = i_grad_20;
    assign w_grad[7] = i_grad_21;
    assign w_grad[8] = i_grad_22;

    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];

    // configuration port
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        case (nhps_pkg::t_reg_idx'(paddr[3:2]))
            nhps_pkg::REG_SHEAR: prdata = 32'(r_mu);
            nhps_pkg::REG_LAME:  prdata = 32'(r_lam);
            nhps_pkg::REG_MODE:  prdata = 32'(r_mode);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu   <= MUW'(65536);
            r_lam  <= MUW'(65536);
            r_mode <= 1'b0;
        end else if (w_wr) begin
            case (nhps_pkg::t_reg_idx'(paddr[3:2]))
                nhps_pkg::REG_SHEAR: r_mu   <= pwdata[MUW-1:0];
                nhps_pkg::REG_LAME:  r_lam  <= pwdata[MUW-1:0];
                nhps_pkg::REG_MODE:  r_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // multiplier arrays
    for (genvar u = 0; u < NU; u++) begin : g_adj
        localparam int I = nhps_pkg::UI[u];
        localparam int J = nhps_pkg::UJ[u];
        nhps_mul #(.A_W(CW), .B_W(CW)) u_m0 (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (r_c[nhps_pkg::uidx((J + 1) % 3, (I + 1) % 3)]),
            .i_b   (r_c[nhps_pkg::uidx((J + 2) % 3, (I + 2) % 3)]),
            .o_p   (w_adjp[u][0])
        );
        nhps_mul #(.A_W(CW), .B_W(CW)) u_m1 (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (r_c[nhps_pkg::uidx((J + 1) % 3, (I + 2) % 3)]),
            .i_b   (r_c[nhps_pkg::uidx((J + 2) % 3, (I + 1) % 3)]),
            .o_p   (w_adjp[u][1])
        );
    end

    for (genvar j = 0; j < 3; j++) begin : g_det
        nhps_mul #(.A_W(CW), .B_W(ADJW)) u_m (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (r_c_d[CD_LEN-1][nhps_pkg::uidx(0, j)]),
            .i_b   (r_adj[nhps_pkg::uidx(0, j)]),
            .o_p   (w_detp[j])
        );
    end

    nhps_mul #(.A_W(DMW), .B_W(FW)) u_kmul (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r_dm),
        .i_b   (signed'({1'b0, r_lam})),
        .o_p   (w_kp)
    );

    for (genvar u = 0; u < NU; u++) begin : g_kq
        nhps_mul #(.A_W(KW), .B_W(QW)) u_m (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (r_k_d[KD_LEN-1]),
            .i_b   (r_q[u]),
            .o_p   (w_kq[u])
        );
    end

    for (genvar e = 0; e < NE; e++) begin : g_pk
        for (genvar m = 0; m < 3; m++) begin : g_m
            nhps_mul #(.A_W(FW), .B_W(SW)) u_m (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_a   (r_f_d[FD_LEN-1][(e / 3) * 3 + m]),
                .i_b   (r_s[nhps_pkg::uidx(m, e % 3)]),
                .o_p   (w_pp[e][m])
            );
        end
    end

    // combinational stage logic
    always_comb begin
        logic signed [CSW-1:0]  v_csum;
        logic signed [DETW-1:0] v_det;
        logic signed [KRW-1:0]  v_kraw;
        for (int u = 0; u < NU; u++) begin
            v_csum = CSW'(r_fp[u][0]) + CSW'(r_fp[u][1]) + CSW'(r_fp[u][2]);
            n_c[u] = CW'(v_csum >>> nhps_pkg::FRAC);
        end
        v_det  = DETW'(w_detp[0]) + DETW'(w_detp[1]) + DETW'(w_detp[2]);
        n_d    = DW'(v_det >>> nhps_pkg::FRAC);
        v_kraw = KRW'(w_kp) - (KRW'(signed'({1'b0, r_mu})) <<< nhps_pkg::MUSH);
        n_k    = KW'(v_kraw >>> nhps_pkg::KSH);
    end

    // divider: load, then two restoring steps per stage
    always_comb begin
        logic signed [AJW-1:0] v_a;
        logic [AJW-1:0]        v_aabs;
        logic [DW-1:0]         v_dabs;
        logic [REMW-1:0]       v_rem;
        logic [NUMW-1:0]       v_nq;
        logic                  v_bit;
        v_dabs = r_d[DW-1] ? (~r_d + 1'b1) : r_d;
        for (int u = 0; u < NU; u++) begin
            v_a    = AJW'(r_adj_d[AD_LEN-1][u] >>> nhps_pkg::FRAC);
            v_aabs = v_a[AJW-1] ? (~v_a + 1'b1) : v_a;
            n_dv_rem[0][u] = '0;
            n_dv_nq[0][u]  = NUMW'({v_aabs, {nhps_pkg::QSH{1'b0}}});
            n_dv_den[0][u] = v_dabs;
            n_dv_neg[0][u] = v_a[AJW-1] ^ r_d[DW-1];
        end
        for (int s = 0; s < DST; s++) begin
            for (int u = 0; u < NU; u++) begin
                v_rem = r_dv_rem[s][u];
                v_nq  = r_dv_nq[s][u];
                for (int b = 0; b < DBPS; b++) begin
                    v_rem = {v_rem[REMW-2:0], v_nq[NUMW-1]};
                    v_bit = (v_rem >= REMW'(r_dv_den[s][u]));
                    if (v_bit) begin
                        v_rem = v_rem - REMW'(r_dv_den[s][u]);
                    end
                    v_nq = {v_nq[NUMW-2:0], v_bit};
                end
                n_dv_rem[s+1][u] = v_rem;
                n_dv_nq[s+1][u]  = v_nq;
                n_dv_den[s+1][u] = r_dv_den[s][u];
                n_dv_neg[s+1][u] = r_dv_neg[s][u];
            end
        end
        for (int u = 0; u < NU; u++) begin
            n_q[u] = r_dv_neg[DST][u] ? -signed'(QW'(r_dv_nq[DST][u]))
                                      : signed'(QW'(r_dv_nq[DST][u]));
        end
    end

    // second Piola-Kirchhoff entries and the first-order sums
    always_comb begin
        logic signed [VW-1:0]  v_s;
        logic signed [PSW-1:0] v_p;
        for (int u = 0; u < NU; u++) begin
            v_s = VW'(signed'(w_kq[u][KQW-1:nhps_pkg::SSH]));
            if (nhps_pkg::UI[u] == nhps_pkg::UJ[u]) begin
                v_s = v_s + VW'(signed'({1'b0, r_mu}));
            end
            if (v_s > VW'(nhps_pkg::S_MAX)) begin
                n_s[u]    = nhps_pkg::S_MAX;
                n_ssat[u] = 1'b1;
            end else if (v_s < VW'(nhps_pkg::S_MIN)) begin
                n_s[u]    = nhps_pkg::S_MIN;
                n_ssat[u] = 1'b1;
            end else begin
                n_s[u]    = SW'(v_s);
                n_ssat[u] = 1'b0;
            end
        end
        for (int e = 0; e < NE; e++) begin
            v_p       = PSW'(w_pp[e][0]) + PSW'(w_pp[e][1]) + PSW'(w_pp[e][2]);
            n_psum[e] = PQW'(v_p >>> nhps_pkg::FRAC);
        end
    end

    // output selection
    always_comb begin
        logic v_psat;
        v_psat = 1'b0;
        for (int e = 0; e < NE; e++) begin
            if (r_psum[e] > PQW'(nhps_pkg::S_MAX)) begin
                n_stress[e] = nhps_pkg::S_MAX;
                v_psat      = 1'b1;
            end else if (r_psum[e] < PQW'(nhps_pkg::S_MIN)) begin
                n_stress[e] = nhps_pkg::S_MIN;
                v_psat      = 1'b1;
            end else begin
                n_stress[e] = SW'(r_psum[e]);
            end
            if (!r_mode) begin
                n_stress[e] = r_s_d[SD_LEN-1][nhps_pkg::uidx(e / 3, e % 3)];
            end
            if (r_sing_d[GD_LEN-1]) begin
                n_stress[e] = '0;
            end
        end
        n_sat = !r_sing_d[GD_LEN-1] && ((|r_ssat_d[SD_LEN-1]) || (r_mode && v_psat));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f   <= w_grad;
            r_f_d[0] <= r_f;
            for (int k = 1; k < FD_LEN; k++) begin
                r_f_d[k] <= r_f_d[k-1];
            end
            for (int u = 0; u < NU; u++) begin
                for (int m = 0; m < 3; m++) begin
                    r_fp[u][m] <= r_f[m*3 + nhps_pkg::UI[u]] * r_f[m*3 + nhps_pkg::UJ[u]];
                end
            end
            r_c <= n_c;
            r_c_d[0] <= r_c;
            for (int k = 1; k < CD_LEN; k++) begin
                r_c_d[k] <= r_c_d[k-1];
            end
            for (int u = 0; u < NU; u++) begin
                r_adj[u] <= ADJW'(w_adjp[u][0]) - ADJW'(w_adjp[u][1]);
            end
            r_adj_d[0] <= r_adj;
            for (int k = 1; k < AD_LEN; k++) begin
                r_adj_d[k] <= r_adj_d[k-1];
            end
            r_d  <= n_d;
            r_dm <= DMW'(r_d) - D_ONE;
            r_k  <= n_k;
            r_k_d[0] <= r_k;
            for (int k = 1; k < KD_LEN; k++) begin
                r_k_d[k] <= r_k_d[k-1];
            end
            r_dv_rem <= n_dv_rem;
            r_dv_nq  <= n_dv_nq;
            r_dv_den <= n_dv_den;
            r_dv_neg <= n_dv_neg;
            r_q      <= n_q;
            r_s      <= n_s;
            r_ssat   <= n_ssat;
            r_s_d[0]    <= r_s;
            r_ssat_d[0] <= r_ssat;
            for (int k = 1; k < SD_LEN; k++) begin
                r_s_d[k]    <= r_s_d[k-1];
                r_ssat_d[k] <= r_ssat_d[k-1];
            end
            r_sing_d <= {r_sing_d[GD_LEN-2:0], (r_d == '0)};
            r_psum   <= n_psum;
            r_stress <= n_stress;
            r_sing   <= r_sing_d[GD_LEN-1];
            r_sat    <= n_sat;
        end
    end

    assign o_stress_00 = r_stress[0];
    assign o_stress_01 = r_stress[1];
    assign o_stress_02 = r_stress[2];
    assign o_stress_10 = r_stress[3];
    assign o_stress_11 = r_stress[4];
    assign o_stress_12 = r_stress[5];
    assign o_stress_20 = r_stress[6];
    assign o_stress_21 = r_stress[7];
    assign o_stress_22 = r_stress[8];
    assign o_singular  = r_sing;
    assign o_saturated = r_sat;

endmodule

// File: hdl/nhps_chk.sv
// Port-level checks for the neo-Hookean stress unit and their bind.
module nhps_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_stall,
    input logic               o_stall,
    input logic               o_valid,
    input logic signed [47:0] o_stress_00,
    input logic signed [47:0] o_stress_11,
    input logic signed [47:0] o_stress_22,
    input logic               o_singular,
    input logic               o_saturated
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_stress_00) && $stable(o_singular)))
        else $error("held item changed");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held output");

    a_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (!o_saturated && o_stress_00 == 48'sd0
                                     && o_stress_11 == 48'sd0 && o_stress_22 == 48'sd0))
        else $error("singular item carries stress or saturation");

    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid straight after reset");

endmodule

bind neo_hookean_piola_stress_unit nhps_chk u_nhps_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_stall     (i_stall),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .o_stress_00 (o_stress_00),
    .o_stress_11 (o_stress_11),
    .o_stress_22 (o_stress_22),
    .o_singular  (o_singular),
    .o_saturated (o_saturated)
);

// File: verif/neo_hookean_piola_stress_unit_test.sv
// Self-checking testbench for the neo-Hookean Piola-Kirchhoff stress unit.
`timescale 1ns / 100ps

module neo_hookean_piola_stress_unit_test;

    typedef logic signed [255:0] t_wide;

    typedef struct {
        nhps_pkg::t_f grad [9];
    } t_grad_item;

    typedef struct {
        nhps_pkg::t_s stress [9];
        logic         singular;
        logic         saturated;
    } t_stress_item;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_valid;
    logic         o_stall;
    nhps_pkg::t_f grad_drv [9];
    logic         o_valid;
    logic         i_stall;
    nhps_pkg::t_s o_stress [9];
    logic         o_singular;
    logic         o_saturated;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    logic [30:0] shear_cfg;
    logic [30:0] lame_cfg;
    logic        first_order_cfg;
    logic        calm;

    t_grad_item   pending_grads [$];
    t_stress_item expected_stress [$];
    t_grad_item   grad_now;
    int           mismatches;
    int           checked;
    int           singular_seen;
    int           saturated_seen;

    neo_hookean_piola_stress_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_grad_00   (grad_drv[0]),
        .i_grad_01   (grad_drv[1]),
        .i_grad_02   (grad_drv[2]),
        .i_grad_10   (grad_drv[3]),
        .i_grad_11   (grad_drv[4]),
        .i_grad_12   (grad_drv[5]),
        .i_grad_20   (grad_drv[6]),
        .i_grad_21   (grad_drv[7]),
        .i_grad_22   (grad_drv[8]),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_stress_00 (o_stress[0]),
        .o_stress_01 (o_stress[1]),
        .o_stress_02 (o_stress[2]),
        .o_stress_10 (o_stress[3]),
        .o_stress_11 (o_stress[4]),
        .o_stress_12 (o_stress[5]),
        .o_stress_20 (o_stress[6]),
        .o_stress_21 (o_stress[7]),
        .o_stress_22 (o_stress[8]),
        .o_singular  (o_singular),
        .o_saturated (o_saturated),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int bit_length(input t_wide v);
        int n;
        t_wide a;
        n = 0;
        a = (v < 0) ? -v : v;
        for (int b = 0; b < 256; b++) if (a[b]) n = b + 1;
        return n;
    endfunction

    function automatic t_wide clip_stress(input t_wide v, inout logic sat);
        t_wide top;
        t_wide bottom;
        top = (t_wide'(1) <<< 47) - 1;
        bottom = -(t_wide'(1) <<< 47);
        if (v > top) begin
            sat = 1'b1;
            return top;
        end
        if (v < bottom) begin
            sat = 1'b1;
            return bottom;
        end
        return v;
    endfunction

    function automatic t_stress_item piola_stress(input t_grad_item g);
        t_stress_item r;
        t_wide f [9];
        t_wide c [3][3];
        t_wide adj [3][3];
        t_wide s [3][3];
        t_wide det_q, k_q, mu, lam, a, q, v, acc;
        logic sat;
        sat = 1'b0;
        mu = {225'd0, shear_cfg};
        lam = {225'd0, lame_cfg};
        for (int i = 0; i < 9; i++) f[i] = g.grad[i];
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int m = 0; m < 3; m++) acc = acc + f[m*3+i] * f[m*3+j];
                c[i][j] = acc >>> nhps_pkg::FRAC;
            end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                adj[i][j] = c[(j+1)%3][(i+1)%3] * c[(j+2)%3][(i+2)%3]
                          - c[(j+1)%3][(i+2)%3] * c[(j+2)%3][(i+1)%3];
        det_q = (c[0][0]*adj[0][0] + c[0][1]*adj[1][0] + c[0][2]*adj[2][0])
                >>> nhps_pkg::FRAC;
        if (det_q == 0) begin
            for (int i = 0; i < 9; i++) r.stress[i] = '0;
            r.singular = 1'b1;
            r.saturated = 1'b0;
            return r;
        end
        k_q = ((det_q - (t_wide'(1) <<< nhps_pkg::DOFF)) * lam - (mu <<< nhps_pkg::MUSH))
              >>> nhps_pkg::KSH;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                a = adj[i][j] >>> nhps_pkg::FRAC;
                q = (a <<< nhps_pkg::QSH) / det_q;
                if (q != 0 && k_q != 0 && bit_length(q) + bit_length(k_q) > 98) begin
                    v = t_wide'(1) <<< 100;
                    if ((q < 0) != (k_q < 0)) v = -v;
                end else begin
                    v = (k_q * q) >>> nhps_pkg::SSH;
                    if (i == j) v = v + mu;
                end
                s[i][j] = clip_stress(v, sat);
            end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                v = s[i][j];
                if (first_order_cfg) begin
                    acc = 0;
                    for (int m = 0; m < 3; m++) acc = acc + f[i*3+m] * s[m][j];
                    v = clip_stress(acc >>> nhps_pkg::FRAC, sat);
                end
                r.stress[i*3+j] = v[nhps_pkg::SW-1:0];
            end
        r.singular = 1'b0;
        r.saturated = sat;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        logic next_valid;
        next_valid = i_valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
            for (int i = 0; i < 9; i++) grad_drv[i] <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_stress.push_back(piola_stress(grad_now));
                next_valid = 1'b0;
            end
            if (!next_valid && pending_grads.size() > 0
                    && (calm || $urandom_range(99) >= 24)) begin
                grad_now = pending_grads.pop_front();
                for (int i = 0; i < 9; i++) grad_drv[i] <= grad_now.grad[i];
                next_valid = 1'b1;
            end
        end
        i_valid <= next_valid;
    end

    // monitor
    always @(posedge i_clk) begin
        t_stress_item want;
        logic bad;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_stress.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected stress item at %0t", $realtime);
            end else begin
                want = expected_stress.pop_front();
                checked++;
                bad = (o_singular !== want.singular) || (o_saturated !== want.saturated);
                for (int i = 0; i < 9; i++) bad |= (o_stress[i] !== want.stress[i]);
                singular_seen += want.singular;
                saturated_seen += want.saturated;
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t: singular %0b/%0b saturated %0b/%0b",
                                 $realtime, want.singular, o_singular,
                                 want.saturated, o_saturated);
                        for (int i = 0; i < 9; i++)
                            $display("  stress[%0d] want %0d got %0d",
                                     i, want.stress[i], o_stress[i]);
                    end
                end
            end
        end
        i_stall <= i_rst_n && !calm && ($urandom_range(99) < 24);
    end

    task automatic write_reg(input nhps_pkg::t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            nhps_pkg::REG_SHEAR: shear_cfg = value[30:0];
            nhps_pkg::REG_LAME:  lame_cfg = value[30:0];
            nhps_pkg::REG_MODE:  first_order_cfg = value[0];
            default: ;
        endcase
    endtask

    task automatic drain;
        while (pending_grads.size() > 0 || i_valid || expected_stress.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic add_fill(input nhps_pkg::t_f v);
        t_grad_item g;
        for (int i = 0; i < 9; i++) g.grad[i] = v;
        pending_grads.push_back(g);
    endtask

    task automatic add_diag(input nhps_pkg::t_f d, input nhps_pkg::t_f off);
        t_grad_item g;
        for (int i = 0; i < 9; i++) g.grad[i] = (i % 4 == 0) ? d : off;
        pending_grads.push_back(g);
    endtask

    function automatic nhps_pkg::t_f jitter(input int bits);
        nhps_pkg::t_f v;
        v = $urandom;
        return v >>> (32 - bits);
    endfunction

    task automatic add_random;
        t_grad_item g;
        int kind;
        int spread;
        kind = $urandom_range(9);
        spread = $urandom_range(4, 29);
        for (int i = 0; i < 9; i++) begin
            case (kind)
                6: g.grad[i] = $urandom;
                8: g.grad[i] = jitter($urandom_range(1, 32));
                9: g.grad[i] = (i % 4 == 0) ? jitter($urandom_range(20, 32)) : '0;
                default: g.grad[i] = ((i % 4 == 0) ? 32'sh1000_0000 : 32'sh0)
                                   + jitter(spread);
            endcase
        end
        if (kind == 7) begin
            for (int i = 0; i < 9; i++) g.grad[i] = $urandom;
            for (int i = 0; i < 3; i++) g.grad[6+i] = g.grad[3+i];
        end
        pending_grads.push_back(g);
    endtask

    task automatic run_random(input int n);
        for (int k = 0; k < n; k++) begin
            if (k == n / 3) calm = 1'b1;
            if (k == n / 2) calm = 1'b0;
            add_random();
            while (pending_grads.size() > 8) @(posedge i_clk);
        end
        drain();
    endtask

    initial begin
        t_grad_item g;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b0;
        shear_cfg = 31'd65536;
        lame_cfg = 31'd65536;
        first_order_cfg = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int m = 0; m < 2; m++) begin
            write_reg(nhps_pkg::REG_MODE, m);
            add_diag(32'sh1000_0000, 32'sh0);
            add_fill(32'sh0);
            add_fill(32'sh7FFF_FFFF);
            add_fill(32'sh8000_0000);
            add_fill(32'sh1000_0000);
            add_diag(32'sh2000_0000, 32'sh0);
            add_diag(32'sh0010_0000, 32'sh0);
            add_diag(32'sh7FFF_FFFF, 32'sh8000_0000);
            add_diag(32'sh8000_0000, 32'sh7FFF_FFFF);
            add_diag(32'shF000_0000, 32'sh0400_0000);
            for (int i = 0; i < 9; i++) g.grad[i] = (i % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            pending_grads.push_back(g);
            drain();
        end

        write_reg(nhps_pkg::REG_MODE, 32'hFFFF_FFFE);
        run_random(360);
        write_reg(nhps_pkg::REG_MODE, 32'd1);
        run_random(360);
        write_reg(nhps_pkg::REG_SHEAR, 32'hFFFF_FFFF);
        write_reg(nhps_pkg::REG_LAME, 32'h7FFF_FFFF);
        run_random(360);
        write_reg(nhps_pkg::REG_SHEAR, 32'd0);
        write_reg(nhps_pkg::REG_LAME, 32'h8000_0000);
        write_reg(nhps_pkg::REG_MODE, 32'd0);
        run_random(360);
        write_reg(nhps_pkg::REG_SHEAR, $urandom_range(32'h0010_0000));
        write_reg(nhps_pkg::REG_LAME, $urandom_range(32'h0100_0000));
        write_reg(nhps_pkg::REG_MODE, $urandom_range(1));
        run_random(360);

        $display("checked %0d stress items over six register settings in both output modes",
                 checked);
        $display("%0d singular and %0d clipped results among them", singular_seen,
                 saturated_seen);
        if (mismatches == 0 && expected_stress.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout");
        $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
hdl/nhps_pkg.sv
hdl/nhps_mul.sv
hdl/neo_hookean_piola_stress_unit.sv
hdl/nhps_chk.sv
verif/neo_hookean_piola_stress_unit_test.sv
